@@ hdl/mmc3bm_pkg.sv @@
`timescale 1ns / 1ps

package mmc3bm_pkg;

  typedef enum logic [1:0] {
    REQ_REG_WRITE = 2'd0,
    REQ_PRG       = 2'd1,
    REQ_CHR_READ  = 2'd2,
    REQ_CHR_WRITE = 2'd3
  } req_kind_e;

  localparam int unsigned NUM_BANK_REGS = 8;
  localparam int unsigned PHYS_W        = 19;

  // CPU register decode: A15..A13 and A0 matter
  localparam logic [15:0] REG_DEC_MASK    = 16'hE001;
  localparam logic [15:0] REG_ADDR_SELECT = 16'h8000;
  localparam logic [15:0] REG_ADDR_DATA   = 16'h8001;

  localparam logic [2:0] PRG_R6_IDX = 3'd6;
  localparam logic [2:0] PRG_R7_IDX = 3'd7;
  localparam logic [5:0] PRG_BANK_SECOND_LAST = 6'h3E;
  localparam logic [5:0] PRG_BANK_LAST        = 6'h3F;

  // bank value 8..15 tags a CHR RAM page
  localparam logic [4:0] CHR_RAM_TAG = 5'b00001;

  localparam int unsigned BS_PRG_SWAP_BIT = 6;
  localparam int unsigned BS_CHR_INV_BIT  = 7;

  typedef logic [7:0] bank_regs_t [NUM_BANK_REGS];

  localparam bank_regs_t BANK_REGS_RESET = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd0};

  typedef struct packed {
    req_kind_e   kind;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [PHYS_W-1:0] phys_address;
    logic              in_chr_ram;
    logic              write_allowed;
  } res_t;

  typedef struct packed {
    logic [7:0] bank_select;
    logic [5:0] prg_mask;
    logic [7:0] chr_mask;
  } map_cfg_t;

endpackage

@@ hdl/mmc3bm_xlate.sv @@
`timescale 1ns / 1ps

module mmc3bm_xlate #(
  parameter int unsigned CHR_RAM_PAGES = 4
) (
  input  mmc3bm_pkg::req_t       req_i,
  input  mmc3bm_pkg::map_cfg_t   cfg_i,
  input  mmc3bm_pkg::bank_regs_t bank_regs_i,
  output mmc3bm_pkg::res_t       res_o
);

  // RAM page = (value & 7) mod CHR_RAM_PAGES, folded at elaboration
  function automatic logic [2:0] ram_page(input logic [2:0] v);
    logic [2:0] p;
    case (v)
      3'd0:    p = 3'(0 % CHR_RAM_PAGES);
      3'd1:    p = 3'(1 % CHR_RAM_PAGES);
      3'd2:    p = 3'(2 % CHR_RAM_PAGES);
      3'd3:    p = 3'(3 % CHR_RAM_PAGES);
      3'd4:    p = 3'(4 % CHR_RAM_PAGES);
      3'd5:    p = 3'(5 % CHR_RAM_PAGES);
      3'd6:    p = 3'(6 % CHR_RAM_PAGES);
      default: p = 3'(7 % CHR_RAM_PAGES);
    endcase
    return p;
  endfunction

  logic       prg_swap;
  logic [5:0] prg_bank;
  logic [2:0] chr_slot;
  logic [2:0] chr_idx;
  logic [7:0] chr_val;
  logic       chr_is_ram;
  logic [mmc3bm_pkg::PHYS_W-1:0] prg_phys;
  logic [mmc3bm_pkg::PHYS_W-1:0] chr_phys;

  assign prg_swap = cfg_i.bank_select[mmc3bm_pkg::BS_PRG_SWAP_BIT];

  always_comb begin
    case (req_i.address[14:13])
      2'd0:    prg_bank = prg_swap ? mmc3bm_pkg::PRG_BANK_SECOND_LAST
                                   : bank_regs_i[mmc3bm_pkg::PRG_R6_IDX][5:0];
      2'd1:    prg_bank = bank_regs_i[mmc3bm_pkg::PRG_R7_IDX][5:0];
      2'd2:    prg_bank = prg_swap ? bank_regs_i[mmc3bm_pkg::PRG_R6_IDX][5:0]
                                   : mmc3bm_pkg::PRG_BANK_SECOND_LAST;
      default: prg_bank = mmc3bm_pkg::PRG_BANK_LAST;
    endcase
  end

  assign prg_phys = {prg_bank & cfg_i.prg_mask, req_i.address[12:0]};

  // invert the CHR halves, then pick the register behind the 1 KiB slot
  assign chr_slot = req_i.address[12:10]
                  ^ {cfg_i.bank_select[mmc3bm_pkg::BS_CHR_INV_BIT], 2'b00};
  assign chr_idx  = chr_slot[2] ? 3'({1'b0, chr_slot[1:0]} + 3'd2)
                                : {2'b00, chr_slot[1]};

  always_comb begin
    chr_val = bank_regs_i[chr_idx];
    if (!chr_slot[2]) begin
      chr_val[0] = chr_slot[0];
    end
  end

  assign chr_is_ram = (chr_val[7:3] == mmc3bm_pkg::CHR_RAM_TAG);

  always_comb begin
    if (chr_is_ram) begin
      chr_phys = {6'd0, ram_page(chr_val[2:0]), req_i.address[9:0]};
    end else begin
      chr_phys = {1'b0, chr_val & cfg_i.chr_mask, req_i.address[9:0]};
    end
  end

  always_comb begin
    res_o = '0;
    unique case (req_i.kind)
      mmc3bm_pkg::REQ_REG_WRITE: begin
        res_o = '0;
      end
      mmc3bm_pkg::REQ_PRG: begin
        if (req_i.address[15]) begin
          res_o.phys_address = prg_phys;
        end
      end
      mmc3bm_pkg::REQ_CHR_READ: begin
        res_o.phys_address = chr_phys;
        res_o.in_chr_ram   = chr_is_ram;
      end
      mmc3bm_pkg::REQ_CHR_WRITE: begin
        res_o.phys_address  = chr_phys;
        res_o.in_chr_ram    = chr_is_ram;
        res_o.write_allowed = chr_is_ram;
      end
      default: res_o = '0;
    endcase
  end

endmodule

@@ hdl/mmc3_bank_mapper_chr_ram_split.sv @@
`timescale 1ns / 1ps

// Channel   Direction  tdata (low bit up)                 tuser (low bit up)
// s_axis    in         address[15:0], data[23:16]         req_type[1:0]
// m_axis    out        phys_address[18:0], zero pad       in_chr_ram[0], write_allowed[1]
// cfg       in         cfg_idx_i 0 prg_bank_mask, 1 chr_bank_mask; no handshake
//
// A beat lands in the input register, is translated and written into the
// result register (bank registers update on that same edge). One beat per
// cycle while m_axis is ready; both stages advance whenever the result
// register is empty or being taken, so a stall on m_axis backs up through
// two stages. Reset restores the bank registers and masks at once; no sweep.

module mmc3_bank_mapper_chr_ram_split #(
  parameter int unsigned CHR_RAM_PAGES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // address[15:0], data[23:16]
  input  logic [1:0]  s_axis_tuser_i,   // req_type[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // phys_address[18:0], zeros[23:19]
  output logic [1:0]  m_axis_tuser_o,   // in_chr_ram[0], write_allowed[1]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  mmc3bm_pkg::req_t       req_q;
  logic                   in_valid_q;
  mmc3bm_pkg::res_t       res_d;
  mmc3bm_pkg::res_t       res_q;
  logic                   out_valid_q;
  logic [7:0]             bank_select_q;
  mmc3bm_pkg::bank_regs_t bank_regs_q;
  logic [5:0]             prg_mask_q;
  logic [7:0]             chr_mask_q;
  mmc3bm_pkg::map_cfg_t   map_cfg;

  logic        out_adv;
  logic        in_fire;
  logic        proc_fire;
  logic [15:0] reg_dec;
  logic        wr_select;
  logic        wr_data;

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || out_adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign proc_fire       = in_valid_q && out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q.kind    <= mmc3bm_pkg::req_kind_e'(s_axis_tuser_i);
      req_q.address <= s_axis_tdata_i[15:0];
      req_q.data    <= s_axis_tdata_i[23:16];
    end
  end

  assign map_cfg.bank_select = bank_select_q;
  assign map_cfg.prg_mask    = prg_mask_q;
  assign map_cfg.chr_mask    = chr_mask_q;

  mmc3bm_xlate #(
    .CHR_RAM_PAGES(CHR_RAM_PAGES)
  ) u_xlate (
    .req_i      (req_q),
    .cfg_i      (map_cfg),
    .bank_regs_i(bank_regs_q),
    .res_o      (res_d)
  );

  // register writes take effect as the beat leaves the input register
  assign reg_dec   = req_q.address & mmc3bm_pkg::REG_DEC_MASK;
  assign wr_select = proc_fire && (req_q.kind == mmc3bm_pkg::REQ_REG_WRITE)
                     && (reg_dec == mmc3bm_pkg::REG_ADDR_SELECT);
  assign wr_data   = proc_fire && (req_q.kind == mmc3bm_pkg::REQ_REG_WRITE)
                     && (reg_dec == mmc3bm_pkg::REG_ADDR_DATA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_select_q <= '0;
      bank_regs_q   <= mmc3bm_pkg::BANK_REGS_RESET;
    end else begin
      if (wr_select) begin
        bank_select_q <= req_q.data;
      end
      if (wr_data) begin
        bank_regs_q[bank_select_q[2:0]] <= req_q.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_mask_q <= 6'h3F;
      chr_mask_q <= 8'hFF;
    end else if (cfg_we_i) begin
      if (cfg_idx_i) begin
        chr_mask_q <= cfg_wdata_i;
      end else begin
        prg_mask_q <= cfg_wdata_i[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, res_q.phys_address};
  assign m_axis_tuser_o  = {res_q.write_allowed, res_q.in_chr_ram};

  a_wr_implies_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.write_allowed |-> res_q.in_chr_ram)
    else $error("write_allowed set outside CHR RAM");

  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input stage empty but not ready");

  a_select_changes_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(bank_select_q) |-> $past(wr_select))
    else $error("bank select changed without a register write");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared with no beat in the input register");

endmodule
